[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros. Every assertion is clocked on clk and is
// disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/krmx_pkg.sv]
// ---------------------------------------------------------------------------
// krmx_pkg
// Types, codes and helper functions shared by the k-unit mutex node and its deferral queue.
// ---------------------------------------------------------------------------
package krmx_pkg;

  localparam int MAX_NODES_DEF   = 16;
  localparam int DEFER_DEPTH_DEF = 16;

  // Node phase codes.
  localparam logic [1:0] PH_IDLE      = 2'd0;
  localparam logic [1:0] PH_COMPETING = 2'd1;
  localparam logic [1:0] PH_ACQUIRED  = 2'd2;

  // Input function codes.
  localparam logic [1:0] FUNC_ACQUIRE = 2'd0;
  localparam logic [1:0] FUNC_RELEASE = 2'd1;
  localparam logic [1:0] FUNC_MESSAGE = 2'd2;

  // Message kinds.
  localparam logic MSG_REQUEST = 1'b0;
  localparam logic MSG_AGREE   = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_OWN_ID = 2'd0;
  localparam logic [1:0] CFG_UNITS  = 2'd1;
  localparam logic [1:0] CFG_MASK   = 2'd2;
  localparam logic [1:0] CFG_KIND   = 2'd3;

  // Control from the sequencer to the deferral queue.
  typedef struct packed {
    logic push;
    logic rd_en;
    logic clear;
  } krmx_qctl_t;

  function automatic logic [2:0] pop4(input logic [3:0] v);
    logic [2:0] c;
    case (v)
      4'h0:                         c = 3'd0;
      4'h1, 4'h2, 4'h4, 4'h8:       c = 3'd1;
      4'h7, 4'hB, 4'hD, 4'hE:       c = 3'd3;
      4'hF:                         c = 3'd4;
      default:                      c = 3'd2;
    endcase
    return c;
  endfunction

  function automatic logic [4:0] popcount16(input logic [15:0] v);
    return 5'(pop4(v[3:0])) + 5'(pop4(v[7:4])) + 5'(pop4(v[11:8])) + 5'(pop4(v[15:12]));
  endfunction

  // Index of the lowest set bit, zero for an empty mask.
  function automatic logic [3:0] lowest_bit(input logic [15:0] m);
    logic [3:0] idx;
    idx = '0;
    for (int i = 15; i >= 0; i--) begin
      if (m[i]) idx = 4'(i);
    end
    return idx;
  endfunction

endpackage

[rtl/krmx_defer_queue.sv]
// ---------------------------------------------------------------------------
// krmx_defer_queue
// Deferred request store: a single-port write, registered-read memory of
// sender and request number, filled in arrival order and cleared as a whole.
// ---------------------------------------------------------------------------
module krmx_defer_queue #(
  parameter int DEFER_DEPTH = krmx_pkg::DEFER_DEPTH_DEF,
  parameter int CAP         = (DEFER_DEPTH < 16) ? DEFER_DEPTH : 16,
  parameter int CW          = $clog2(CAP + 1),
  parameter int AW          = (CAP > 1) ? $clog2(CAP) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  krmx_pkg::krmx_qctl_t ctl,
  input  logic [3:0]          wr_sender,
  input  logic [31:0]         wr_sig,
  input  logic [AW-1:0]       rd_idx,
  output logic [CW-1:0]       count,
  output logic                full,
  output logic [3:0]          rd_sender,
  output logic [31:0]         rd_sig
);
  import krmx_pkg::*;

  // Entries beyond the fill count are never read, so the memory has no reset.
  logic [35:0] mem [CAP];
  logic [35:0] rd_q;

  assign full = (count == CW'(CAP));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.clear) begin
      count <= '0;
    end else if (ctl.push && !full) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push && !full) begin
      mem[count[AW-1:0]] <= {wr_sender, wr_sig};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_q <= mem[rd_idx];
    end
  end

  assign rd_sender = rd_q[35:32];
  assign rd_sig    = rd_q[31:0];

  `include "assert_macros.svh"

  `ASSERT_ALWAYS(a_count_bound, count <= CW'(CAP), "deferral count beyond capacity")
  `ASSERT_NEXT(a_full_hold, ctl.push && full && !ctl.clear, $stable(count), "push into full queue changed count")
  `ASSERT_NEXT(a_clear_empty, ctl.clear, count == '0, "clear left entries in the queue")

endmodule

[rtl/k_resource_mutex_node.sv]
// ---------------------------------------------------------------------------
// k_resource_mutex_node
// One node of a k-unit mutual exclusion in the Ricart-Agrawala style.
// ---------------------------------------------------------------------------
// The node takes one request at a time. A received message, or an unused
// function code, is latched on acceptance and its single result is
// registered from the execute state once the output is free. An acquire
// sends one Request to each peer through the single output register, the
// Requests leaving one per cycle while the output is not stalled. A release
// sends each deferred request an Agree: each entry is read from the deferral
// memory, whose read data is registered, before it is sent. A stalled output
// holds back each result. Configuration writes are taken in every cycle; the
// node needs no clearing pass after reset.
module k_resource_mutex_node #(
  parameter int MAX_NODES   = krmx_pkg::MAX_NODES_DEF,
  parameter int DEFER_DEPTH = krmx_pkg::DEFER_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input requests
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic        msg_type,
  input  logic [3:0]  msg_sender,
  input  logic [31:0] msg_signature,
  input  logic [31:0] msg_clock,
  input  logic [31:0] lamport_now,
  // results
  output logic        out_valid,
  input  logic        out_ready,
  output logic        send_valid,
  output logic        send_type,
  output logic [3:0]  destination,
  output logic [31:0] out_signature,
  output logic [31:0] out_priority,
  output logic [7:0]  out_kind,
  output logic [1:0]  node_state,
  output logic        acquired_now,
  output logic        defer_overflow,
  output logic        last
);
  import krmx_pkg::*;

  localparam int NODE_LIM = (MAX_NODES < 16) ? MAX_NODES : 16;
  localparam logic [15:0] LIM_MASK =
    (NODE_LIM >= 16) ? 16'hFFFF : 16'((32'd1 << NODE_LIM) - 32'd1);
  localparam int CAP = (DEFER_DEPTH < 16) ? DEFER_DEPTH : 16;
  localparam int CW  = $clog2(CAP + 1);
  localparam int AW  = (CAP > 1) ? $clog2(CAP) : 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_FAN  = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_DRN  = 3'd4;

  // Configuration registers.
  logic [3:0]  own_id;
  logic [3:0]  units;
  logic [15:0] mask;
  logic [7:0]  kind;
  logic [15:0] peers;
  logic [4:0]  peer_cnt;

  // Node state.
  logic [2:0]  st, st_next;
  logic [1:0]  phase, phase_next;
  logic [4:0]  permit, permit_next;
  logic [31:0] serial, serial_next;
  logic [31:0] own_prio, prio_next;
  logic [15:0] fan_mask, fan_next;
  logic [CW-1:0] rd_idx, rd_idx_next;
  logic        acq_flag, acq_next;
  logic        ovf_flag, ovf_next;

  // Latched request.
  logic [1:0]  it_func;
  logic        it_type;
  logic [3:0]  it_sender;
  logic [31:0] it_sig;
  logic [31:0] it_clock;
  logic [31:0] it_now;

  // Step decision.
  logic [1:0]  ex_phase;
  logic [4:0]  ex_permit;
  logic [4:0]  permit_inc;
  logic        ex_acq, ex_ovf, ex_push, ex_agree, later;

  // Result load.
  logic        out_free, ld, ld_send, ld_type, ld_acq, ld_ovf, ld_last;
  logic [3:0]  ld_dest;
  logic [31:0] ld_sig, ld_prio;
  logic [1:0]  ld_state;
  logic [3:0]  fan_first;
  logic [15:0] fan_rest;

  // Queue interface.
  krmx_qctl_t  qctl;
  logic [CW-1:0] q_count;
  logic        q_full;
  logic [3:0]  q_sender;
  logic [31:0] q_sig;

  assign cfg_ready = 1'b1;
  assign in_ready  = (st == ST_IDLE);
  assign out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_id <= '0;
      units  <= 4'd1;
      mask   <= '0;
      kind   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_OWN_ID: own_id <= cfg_data[3:0];
        CFG_UNITS:  units  <= cfg_data[3:0];
        CFG_MASK:   mask   <= cfg_data;
        CFG_KIND:   kind   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign peers = mask & ~(16'd1 << own_id) & LIM_MASK;

  // The peer count is registered; the user, unchecked by the node, lets configuration settle before any request runs.
  always_ff @(posedge clk) begin
    peer_cnt <= popcount16(peers);
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      it_func   <= func;
      it_type   <= msg_type;
      it_sender <= msg_sender;
      it_sig    <= msg_signature;
      it_clock  <= msg_clock;
      it_now    <= lamport_now;
    end
  end

  // What one request does to the node, before any fan-out.
  always_comb begin
    ex_phase   = phase;
    ex_permit  = permit;
    ex_acq     = 1'b0;
    ex_ovf     = 1'b0;
    ex_push    = 1'b0;
    ex_agree   = 1'b0;
    permit_inc = (permit == 5'd31) ? permit : permit + 5'd1;
    // A newer request, or an equal one from a higher id, waits for our release.
    later = (it_clock > own_prio) || ((it_clock == own_prio) && (it_sender > own_id));
    case (it_func)
      FUNC_ACQUIRE: begin
        ex_permit = '0;
        ex_acq    = ({1'b0, units} > peer_cnt);
        ex_phase  = ex_acq ? PH_ACQUIRED : PH_COMPETING;
      end
      FUNC_RELEASE: begin
        ex_phase = PH_IDLE;
      end
      FUNC_MESSAGE: begin
        case (phase)
          PH_IDLE: begin
            ex_agree = (it_type == MSG_REQUEST);
          end
          PH_COMPETING: begin
            if (it_type == MSG_REQUEST) begin
              if (later) begin
                ex_push = !q_full;
                ex_ovf  = q_full;
              end else begin
                ex_agree = 1'b1;
              end
            end else if (it_sig == serial) begin
              ex_permit = permit_inc;
              if (6'(permit_inc) + 6'(units) > 6'(peer_cnt)) begin
                ex_phase = PH_ACQUIRED;
                ex_acq   = 1'b1;
              end
            end
          end
          PH_ACQUIRED: begin
            if (it_type == MSG_REQUEST) begin
              ex_push = !q_full;
              ex_ovf  = q_full;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign fan_first = lowest_bit(fan_mask);
  assign fan_rest  = fan_mask & (fan_mask - 16'd1);

  always_comb begin
    st_next     = st;
    phase_next  = phase;
    permit_next = permit;
    serial_next = serial;
    prio_next   = own_prio;
    fan_next    = fan_mask;
    rd_idx_next = rd_idx;
    acq_next    = acq_flag;
    ovf_next    = ovf_flag;
    qctl        = '0;
    ld          = 1'b0;
    ld_send     = 1'b0;
    ld_type     = MSG_REQUEST;
    ld_dest     = '0;
    ld_sig      = '0;
    ld_prio     = '0;
    ld_state    = phase;
    ld_acq      = acq_flag;
    ld_ovf      = ovf_flag;
    ld_last     = 1'b1;
    case (st)
      ST_IDLE: begin
        if (in_valid) st_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) begin
          ld          = 1'b1;
          ld_state    = ex_phase;
          ld_acq      = ex_acq;
          ld_ovf      = ex_ovf;
          phase_next  = ex_phase;
          permit_next = ex_permit;
          acq_next    = ex_acq;
          ovf_next    = ex_ovf;
          qctl.push   = ex_push;
          st_next     = ST_IDLE;
          if (ex_agree) begin
            ld_send = 1'b1;
            ld_type = MSG_AGREE;
            ld_dest = it_sender;
            ld_sig  = it_sig;
          end
          if (it_func == FUNC_ACQUIRE) begin
            serial_next = serial + 32'd1;
            prio_next   = it_now;
            if (peers != '0) begin
              ld       = 1'b0;
              fan_next = peers;
              st_next  = ST_FAN;
            end
          end
          if (it_func == FUNC_RELEASE && q_count != '0) begin
            ld          = 1'b0;
            rd_idx_next = '0;
            st_next     = ST_RD;
          end
        end
      end
      ST_FAN: begin
        if (out_free) begin
          ld       = 1'b1;
          ld_send  = 1'b1;
          ld_type  = MSG_REQUEST;
          ld_dest  = fan_first;
          ld_sig   = serial;
          ld_prio  = own_prio;
          ld_last  = (fan_rest == '0);
          fan_next = fan_rest;
          if (fan_rest == '0) st_next = ST_IDLE;
        end
      end
      ST_RD: begin
        qctl.rd_en = 1'b1;
        st_next    = ST_DRN;
      end
      ST_DRN: begin
        if (out_free) begin
          ld      = 1'b1;
          ld_send = 1'b1;
          ld_type = MSG_AGREE;
          ld_dest = q_sender;
          ld_sig  = q_sig;
          ld_last = (rd_idx + CW'(1) == q_count);
          if (ld_last) begin
            qctl.clear = 1'b1;
            st_next    = ST_IDLE;
          end else begin
            rd_idx_next = rd_idx + CW'(1);
            st_next     = ST_RD;
          end
        end
      end
      default: st_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= ST_IDLE;
      phase    <= PH_IDLE;
      permit   <= '0;
      serial   <= '0;
      own_prio <= '0;
      fan_mask <= '0;
      rd_idx   <= '0;
      acq_flag <= 1'b0;
      ovf_flag <= 1'b0;
    end else begin
      st       <= st_next;
      phase    <= phase_next;
      permit   <= permit_next;
      serial   <= serial_next;
      own_prio <= prio_next;
      fan_mask <= fan_next;
      rd_idx   <= rd_idx_next;
      acq_flag <= acq_next;
      ovf_flag <= ovf_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      send_valid     <= ld_send;
      send_type      <= ld_type;
      destination    <= ld_dest;
      out_signature  <= ld_sig;
      out_priority   <= ld_prio;
      out_kind       <= ld_send ? kind : 8'd0;
      node_state     <= ld_state;
      acquired_now   <= ld_acq;
      defer_overflow <= ld_ovf;
      last           <= ld_last;
    end
  end

  krmx_defer_queue #(
    .DEFER_DEPTH(DEFER_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .ctl       (qctl),
    .wr_sender (it_sender),
    .wr_sig    (it_sig),
    .rd_idx    (rd_idx[AW-1:0]),
    .count     (q_count),
    .full      (q_full),
    .rd_sender (q_sender),
    .rd_sig    (q_sig)
  );

  `include "assert_macros.svh"

  `ASSERT_IMPLY(a_acq_state, out_valid && acquired_now, node_state == PH_ACQUIRED, "acquired_now without acquired state")
  `ASSERT_IMPLY(a_ovf_empty, out_valid && defer_overflow, !send_valid && last, "dropped request produced a message")
  `ASSERT_IMPLY(a_req_phase, out_valid && send_valid && send_type == MSG_REQUEST, node_state != PH_IDLE, "Request sent while idle")

endmodule
